// ----- hdl/dlr_pkg.sv -----
`default_nettype none

package dlr_pkg;

	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS_DEFAULT = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam logic OP_START = 1'b0;
	localparam logic OP_ADVANCE = 1'b1;

	typedef struct packed {
		logic operation;
		logic [COORD_BITS-1:0] start_x;
		logic [COORD_BITS-1:0] start_y;
		logic [COORD_BITS-1:0] end_x;
		logic [COORD_BITS-1:0] end_y;
	} dlr_in_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] point_x;
		logic [COORD_BITS-1:0] point_y;
		logic last_point;
	} dlr_out_t;

	// Classified command handed from the front to the back.
	typedef struct packed {
		logic is_start;
		logic [COORD_BITS-1:0] start_x;
		logic [COORD_BITS-1:0] start_y;
		logic [COORD_BITS-1:0] span;
		logic [COORD_BITS-1:0] minor_mag;
		logic major_x;
		logic neg_x;
		logic neg_y;
	} dlr_cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIVIDE,
		BK_EMIT
	} dlr_back_state_t;

endpackage

`default_nettype wire

// ----- hdl/dda_line_rasterizer.sv -----
// DDA line rasterizer.
// The input channel (in_valid, in_ready, in_data) takes one transaction per
// command: operation start loads two endpoints, operation advance asks for
// the next point of the current line. The output channel (out_valid,
// out_ready, out_data) returns the points, last_point marking the final one.
// An advance with no line in progress returns nothing.
// A front stage registers and classifies each command and writes it into a
// two-entry queue; the back end pops commands and does the stepping.
// An advance passes through the front stage and the queue, and the stepping
// adders put its point into the output register; the block sustains one
// advance per cycle while out_ready stays high and no start is dividing.
// A start runs a restoring divider for the minor-axis increment, one bit per
// cycle, and the next command waits behind it in the queue. A zero-length
// line skips the divider and goes straight to giving its first point.
// Reset clears the queue, the output valid flag and the line state; the block
// comes up idle with no line in progress.
// When the receiver stalls, the output register holds its point, the back end
// stops at the next point it must give, and the queue and front stage fill before in_ready drops.
`default_nettype none

module dda_line_rasterizer #(
	parameter int FRAC_BITS = dlr_pkg::FRAC_BITS_DEFAULT
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire dlr_pkg::dlr_in_t in_data,
	output logic out_valid,
	input  wire logic out_ready,
	output dlr_pkg::dlr_out_t out_data
);

	logic push_valid;
	logic push_ready;
	dlr_pkg::dlr_cmd_t push_data;
	logic pop_valid;
	logic pop_ready;
	dlr_pkg::dlr_cmd_t pop_data;

	dlr_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_data)
	);

	dlr_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_data),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_data)
	);

	dlr_back #(
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

endmodule

`default_nettype wire

// ----- hdl/dlr_front.sv -----
`default_nettype none

module dlr_front (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire dlr_pkg::dlr_in_t in_data,
	output logic push_valid,
	input  wire logic push_ready,
	output dlr_pkg::dlr_cmd_t push_data
);

	localparam int CB = dlr_pkg::COORD_BITS;

	logic valid_s1;
	dlr_pkg::dlr_cmd_t cmd_s1;
	dlr_pkg::dlr_cmd_t cmd_d;

	logic signed [CB:0] dx;
	logic signed [CB:0] dy;
	logic [CB-1:0] ax;
	logic [CB-1:0] ay;

	always_comb begin
		dx = $signed({1'b0, in_data.end_x}) - $signed({1'b0, in_data.start_x});
		dy = $signed({1'b0, in_data.end_y}) - $signed({1'b0, in_data.start_y});
		ax = dx[CB] ? CB'(-dx) : dx[CB-1:0];
		ay = dy[CB] ? CB'(-dy) : dy[CB-1:0];
		cmd_d.is_start = (in_data.operation == dlr_pkg::OP_START);
		cmd_d.start_x = in_data.start_x;
		cmd_d.start_y = in_data.start_y;
		// Ties go to x; both increments then come out at full magnitude.
		cmd_d.major_x = (ax >= ay);
		cmd_d.span = (ax >= ay) ? ax : ay;
		cmd_d.minor_mag = (ax >= ay) ? ay : ax;
		cmd_d.neg_x = dx[CB];
		cmd_d.neg_y = dy[CB];
	end

	assign in_ready = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_data = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= cmd_d;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/dlr_queue.sv -----
`default_nettype none

module dlr_queue (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_valid,
	output logic push_ready,
	input  wire dlr_pkg::dlr_cmd_t push_data,
	output logic pop_valid,
	input  wire logic pop_ready,
	output dlr_pkg::dlr_cmd_t pop_data
);

	localparam int DEPTH = dlr_pkg::QUEUE_DEPTH;
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	dlr_pkg::dlr_cmd_t entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data = entry_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/dlr_back.sv -----
`default_nettype none

module dlr_back #(
	parameter int FRAC_BITS = dlr_pkg::FRAC_BITS_DEFAULT
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic pop_valid,
	output logic pop_ready,
	input  wire dlr_pkg::dlr_cmd_t pop_data,
	output logic out_valid,
	input  wire logic out_ready,
	output dlr_pkg::dlr_out_t out_data
);

	localparam int CB = dlr_pkg::COORD_BITS;
	localparam int AW = CB + FRAC_BITS + 2;
	localparam int SW = FRAC_BITS + 2;
	localparam int NW = $clog2(FRAC_BITS + 1);

	dlr_pkg::dlr_back_state_t state_q;
	dlr_pkg::dlr_back_state_t state_d;

	// The accumulators hold the position plus one half, so rounding is a shift.
	logic signed [AW-1:0] accum_x_q;
	logic signed [AW-1:0] accum_y_q;
	logic signed [SW-1:0] step_x_q;
	logic signed [SW-1:0] step_y_q;
	logic [CB-1:0] points_left_q;
	logic line_active_q;

	logic [CB-1:0] span_q;
	logic [CB-1:0] rem_q;
	logic [FRAC_BITS:0] quot_q;
	logic [NW-1:0] div_cnt_q;
	logic major_x_q;
	logic neg_x_q;
	logic neg_y_q;

	logic out_valid_q;
	dlr_pkg::dlr_out_t out_q;

	logic slot_free;
	logic do_load;
	logic do_advance;
	logic do_divide;
	logic do_emit;

	logic signed [AW-1:0] next_x;
	logic signed [AW-1:0] next_y;
	logic [CB-1:0] pl_next;
	logic [CB:0] rem_sh;
	logic rem_ge;
	logic signed [SW-1:0] minor_step;
	logic signed [SW-1:0] major_step;
	logic minor_eq;

	localparam logic signed [AW-1:0] HALF = AW'(1) << (FRAC_BITS - 1);

	function automatic logic [CB-1:0] round_coord(input logic signed [AW-1:0] v);
		logic [CB:0] r;
		r = v[AW-2:FRAC_BITS];
		if (v[AW-1]) begin
			round_coord = '0;
		end else if (r[CB]) begin
			round_coord = '1;
		end else begin
			round_coord = r[CB-1:0];
		end
	endfunction

	function automatic logic signed [SW-1:0] apply_sign(input logic signed [SW-1:0] m,
			input logic neg);
		apply_sign = neg ? -m : m;
	endfunction

	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	assign next_x = accum_x_q + AW'(step_x_q);
	assign next_y = accum_y_q + AW'(step_y_q);
	assign pl_next = points_left_q - CB'(1);
	assign rem_sh = {rem_q, 1'b0};
	assign rem_ge = (rem_sh >= {1'b0, span_q});
	assign minor_step = $signed({1'b0, quot_q});
	assign major_step = SW'(1) << FRAC_BITS;
	assign minor_eq = (pop_data.minor_mag == pop_data.span);

	always_comb begin
		state_d = state_q;
		pop_ready = 1'b0;
		do_load = 1'b0;
		do_advance = 1'b0;
		do_divide = 1'b0;
		do_emit = 1'b0;
		case (state_q)
			dlr_pkg::BK_IDLE: begin
				if (pop_valid) begin
					if (pop_data.is_start) begin
						pop_ready = 1'b1;
						do_load = 1'b1;
						state_d = (pop_data.span == '0) ? dlr_pkg::BK_EMIT
							: dlr_pkg::BK_DIVIDE;
					end else if (!line_active_q) begin
						// Nothing to advance: the transaction is dropped.
						pop_ready = 1'b1;
					end else if (slot_free) begin
						pop_ready = 1'b1;
						do_advance = 1'b1;
					end
				end
			end
			dlr_pkg::BK_DIVIDE: begin
				do_divide = 1'b1;
				if (div_cnt_q == NW'(1)) begin
					state_d = dlr_pkg::BK_EMIT;
				end
			end
			dlr_pkg::BK_EMIT: begin
				if (slot_free) begin
					do_emit = 1'b1;
					state_d = dlr_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = dlr_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dlr_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_x_q <= '0;
			accum_y_q <= '0;
			step_x_q <= '0;
			step_y_q <= '0;
			points_left_q <= '0;
			line_active_q <= 1'b0;
			div_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_load) begin
				accum_x_q <= AW'({pop_data.start_x, FRAC_BITS'(0)}) | HALF;
				accum_y_q <= AW'({pop_data.start_y, FRAC_BITS'(0)}) | HALF;
				points_left_q <= pop_data.span;
				line_active_q <= (pop_data.span != '0);
				div_cnt_q <= NW'(FRAC_BITS);
			end else if (do_advance) begin
				accum_x_q <= next_x;
				accum_y_q <= next_y;
				points_left_q <= pl_next;
				line_active_q <= (pl_next != '0);
			end else if (do_divide) begin
				div_cnt_q <= div_cnt_q - NW'(1);
			end
			if (do_emit) begin
				step_x_q <= apply_sign(major_x_q ? major_step : minor_step, neg_x_q);
				step_y_q <= apply_sign(major_x_q ? minor_step : major_step, neg_y_q);
			end
			if (do_emit || do_advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Restoring divider for the minor axis: one quotient bit per cycle.
	always_ff @(posedge clk) begin
		if (do_load) begin
			span_q <= pop_data.span;
			major_x_q <= pop_data.major_x;
			neg_x_q <= pop_data.neg_x;
			neg_y_q <= pop_data.neg_y;
			rem_q <= minor_eq ? '0 : pop_data.minor_mag;
			quot_q <= {FRAC_BITS'(0), minor_eq};
		end else if (do_divide) begin
			rem_q <= rem_ge ? CB'(rem_sh - {1'b0, span_q}) : rem_sh[CB-1:0];
			quot_q <= {quot_q[FRAC_BITS-1:0], rem_ge};
		end
	end

	always_ff @(posedge clk) begin
		if (do_emit) begin
			out_q.point_x <= round_coord(accum_x_q);
			out_q.point_y <= round_coord(accum_y_q);
			out_q.last_point <= !line_active_q;
		end else if (do_advance) begin
			out_q.point_x <= round_coord(next_x);
			out_q.point_y <= round_coord(next_y);
			out_q.last_point <= (pl_next == '0);
		end
	end

endmodule

`default_nettype wire
